// ===== hdl/csl_pkg.sv =====
package csl_pkg;

  // Default configuration
  localparam int CSL_POSITION_BITS = 16;
  localparam int CSL_KEYWORD_CHARS = 7;

  localparam int CSL_LEN_W = 16;
  localparam int CSL_NUM_KEYWORDS = 15;

  // Token kinds
  localparam logic [5:0] K_END          = 6'd0;
  localparam logic [5:0] K_IDENT        = 6'd1;
  localparam logic [5:0] K_INT          = 6'd2;
  localparam logic [5:0] K_FLOAT        = 6'd3;
  localparam logic [5:0] K_STRING       = 6'd4;
  localparam logic [5:0] K_CHAR         = 6'd5;
  localparam logic [5:0] K_KW_FIRST     = 6'd6;
  localparam logic [5:0] K_PAIR_FIRST   = 6'd21;
  localparam logic [5:0] K_SINGLE_FIRST = 6'd28;
  localparam logic [5:0] K_ERROR        = 6'd51;

  // Characters with a role of their own
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Scanner modes
  typedef enum logic [3:0] {
    M_IDLE,
    M_WORD,
    M_NUMBER,
    M_STRING,
    M_QUOTE_OPEN,
    M_QUOTE_VALUE,
    M_HELD,
    M_LINE_REM,
    M_BLOCK_REM,
    M_BLOCK_STAR,
    M_ERROR
  } csl_mode_t;

  // Token pushes from the scanner into the token queue
  typedef struct packed {
    logic p0;
    logic p1;
  } csl_push_t;

  // Keyword entry: length and text packed first character lowest
  typedef struct packed {
    logic [3:0]  len;
    logic [63:0] text;
  } csl_kw_t;

  function automatic logic csl_is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic csl_is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic csl_is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic csl_may_pair(input logic [7:0] c);
    return c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|" ||
           c == "-" || c == CH_SLASH;
  endfunction

  // Single-character token kind, zero when the byte is none of them
  function automatic logic [5:0] csl_single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+":      k = K_SINGLE_FIRST + 6'd0;
      "-":      k = K_SINGLE_FIRST + 6'd1;
      "*":      k = K_SINGLE_FIRST + 6'd2;
      "/":      k = K_SINGLE_FIRST + 6'd3;
      "%":      k = K_SINGLE_FIRST + 6'd4;
      "&":      k = K_SINGLE_FIRST + 6'd5;
      "|":      k = K_SINGLE_FIRST + 6'd6;
      "^":      k = K_SINGLE_FIRST + 6'd7;
      "!":      k = K_SINGLE_FIRST + 6'd8;
      "~":      k = K_SINGLE_FIRST + 6'd9;
      "=":      k = K_SINGLE_FIRST + 6'd10;
      "<":      k = K_SINGLE_FIRST + 6'd11;
      ">":      k = K_SINGLE_FIRST + 6'd12;
      "(":      k = K_SINGLE_FIRST + 6'd13;
      ")":      k = K_SINGLE_FIRST + 6'd14;
      "{":      k = K_SINGLE_FIRST + 6'd15;
      "}":      k = K_SINGLE_FIRST + 6'd16;
      "[":      k = K_SINGLE_FIRST + 6'd17;
      "]":      k = K_SINGLE_FIRST + 6'd18;
      ",":      k = K_SINGLE_FIRST + 6'd19;
      ";":      k = K_SINGLE_FIRST + 6'd20;
      ":":      k = K_SINGLE_FIRST + 6'd21;
      CH_DOT:   k = K_SINGLE_FIRST + 6'd22;
      default:  k = 6'd0;
    endcase
    return k;
  endfunction

  // Two-character operator kind, zero when the pair is not an operator
  function automatic logic [5:0] csl_pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] k;
    k = 6'd0;
    if (a == "=" && b == "=") k = K_PAIR_FIRST + 6'd0;
    if (a == "!" && b == "=") k = K_PAIR_FIRST + 6'd1;
    if (a == "<" && b == "=") k = K_PAIR_FIRST + 6'd2;
    if (a == ">" && b == "=") k = K_PAIR_FIRST + 6'd3;
    if (a == "&" && b == "&") k = K_PAIR_FIRST + 6'd4;
    if (a == "|" && b == "|") k = K_PAIR_FIRST + 6'd5;
    if (a == "-" && b == ">") k = K_PAIR_FIRST + 6'd6;
    return k;
  endfunction

  // Keyword table, text repacked so the first character is the low byte
  function automatic csl_kw_t csl_keyword(input logic [3:0] k);
    logic [63:0] s;
    logic [3:0]  n;
    csl_kw_t     r;
    case (k)
      4'd0:    begin s = "int";     n = 4'd3; end
      4'd1:    begin s = "char";    n = 4'd4; end
      4'd2:    begin s = "float";   n = 4'd5; end
      4'd3:    begin s = "double";  n = 4'd6; end
      4'd4:    begin s = "bool";    n = 4'd4; end
      4'd5:    begin s = "void";    n = 4'd4; end
      4'd6:    begin s = "struct";  n = 4'd6; end
      4'd7:    begin s = "if";      n = 4'd2; end
      4'd8:    begin s = "else";    n = 4'd4; end
      4'd9:    begin s = "while";   n = 4'd5; end
      4'd10:   begin s = "for";     n = 4'd3; end
      4'd11:   begin s = "switch";  n = 4'd6; end
      4'd12:   begin s = "case";    n = 4'd4; end
      4'd13:   begin s = "default"; n = 4'd7; end
      4'd14:   begin s = "return";  n = 4'd6; end
      default: begin s = '0;        n = 4'd0; end
    endcase
    r.len  = n;
    r.text = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(n)) r.text[8*i +: 8] = s[8*(int'(n)-1-i) +: 8];
    end
    return r;
  endfunction

endpackage

// ===== hdl/csl_in_if.sv =====
interface csl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;

  modport source (output valid, source_byte, end_of_source, input ready);
  modport sink   (input valid, source_byte, end_of_source, output ready);
endinterface

// ===== hdl/csl_out_if.sv =====
interface csl_out_if #(
  parameter int POS_W = csl_pkg::CSL_POSITION_BITS
);
  logic             valid;
  logic             ready;
  logic [5:0]       token_kind;
  logic [POS_W-1:0] start_line;
  logic [POS_W-1:0] start_column;
  logic [15:0]      token_length;
  logic [7:0]       char_value;
  logic             last_of_run;

  modport source (output valid, token_kind, start_line, start_column, token_length,
                  char_value, last_of_run, input ready);
  modport sink   (input valid, token_kind, start_line, start_column, token_length,
                  char_value, last_of_run, output ready);
endinterface

// ===== hdl/c_subset_lexer_top.sv =====
// Streaming tokenizer for a small C subset. One source byte (or end marker) is taken per
// request; a registered byte is scanned combinationally and its tokens, at most two, are
// written into a four-entry token queue that drives the result channel. Input is accepted
// in every cycle while the queue has room for two tokens, so the sustained rate is one byte
// per cycle; a byte that both closes a token and opens a one-character token, and every end
// marker after a pending token, gives two tokens, so the result port's single token
// per cycle sets the rate for such runs. Both the input stage and the token queue are
// registered. Positions are 1-based and saturate at 2^POSITION_BITS-1, lengths at 65535;
// after an error token all bytes are dropped until the end marker, which restores reset.
module c_subset_lexer_top #(
  parameter int POSITION_BITS = csl_pkg::CSL_POSITION_BITS,
  parameter int KEYWORD_CHARS = csl_pkg::CSL_KEYWORD_CHARS
) (
  input  logic     clk,
  input  logic     rst_n,
  csl_in_if.sink   in_chan,
  csl_out_if.source out_chan
);
  import csl_pkg::*;

  localparam int TOK_W = 2*POSITION_BITS + 31;

  logic             iv_r;
  logic [7:0]       byte_r;
  logic             eos_r;
  logic             adv;
  logic             room;
  logic             end_w;
  csl_push_t        push_s;
  logic [TOK_W-1:0] tok0, tok1;

  // Input register stage
  assign adv           = iv_r && room;
  assign in_chan.ready = !iv_r || adv;
  assign end_w         = eos_r || (byte_r == 8'h00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_chan.ready) begin
      iv_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      byte_r <= in_chan.source_byte;
      eos_r  <= in_chan.end_of_source;
    end
  end

  // Scanner
  csl_scan #(
    .POSITION_BITS (POSITION_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (adv),
    .source_byte   (byte_r),
    .end_of_source (eos_r),
    .push          (push_s),
    .tok0          (tok0),
    .tok1          (tok1)
  );

  // Token queue
  csl_tokq #(
    .POSITION_BITS (POSITION_BITS)
  ) u_tokq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_s),
    .tok0     (tok0),
    .tok1     (tok1),
    .room     (room),
    .out_chan (out_chan)
  );

  // Checks
  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push_s.p1 |-> push_s.p0)
    else $error("second token pushed without a first");

  a_end_gives_token: assert property (@(posedge clk) disable iff (!rst_n)
    adv && end_w |-> push_s.p0)
    else $error("end marker produced no token");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push_s.p0 |=> out_chan.valid)
    else $error("pushed token not offered on the result channel");

  a_push_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    push_s.p0 |-> adv)
    else $error("token pushed without an accepted byte");

endmodule

// ===== hdl/csl_scan.sv =====
module csl_scan #(
  parameter int  POSITION_BITS = csl_pkg::CSL_POSITION_BITS,
  parameter int  KEYWORD_CHARS = csl_pkg::CSL_KEYWORD_CHARS,
  localparam int TOK_W         = 2*POSITION_BITS + 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         source_byte,
  input  logic               end_of_source,
  output csl_pkg::csl_push_t push,
  output logic [TOK_W-1:0]   tok0,
  output logic [TOK_W-1:0]   tok1
);
  import csl_pkg::*;

  localparam int P    = POSITION_BITS;
  localparam int WIN_W = 8*KEYWORD_CHARS;
  localparam logic [P-1:0] POS_MAX = '1;
  localparam logic [P-1:0] POS_ONE = P'(1);
  localparam logic [CSL_LEN_W-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic [5:0]           kind;
    logic [P-1:0]         line;
    logic [P-1:0]         col;
    logic [CSL_LEN_W-1:0] len;
    logic [7:0]           cval;
    logic                 last;
  } tok_t;

  // Scanner state
  csl_mode_t            mode_r, mode_nxt;
  logic [7:0]           held_r, held_nxt;
  logic                 dot_r, dot_nxt;
  logic [WIN_W-1:0]     win_r, win_nxt;
  logic [CSL_LEN_W-1:0] run_r, run_nxt;
  logic [P-1:0]         tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic [P-1:0]         cline_r, cline_nxt, ccol_r, ccol_nxt;
  logic [7:0]           lit_r, lit_nxt;

  logic                 at_end;
  logic [CSL_LEN_W-1:0] run_inc;
  logic [5:0]           word_kind, pair_k, single_k;
  logic                 fl_v;
  tok_t                 fl_tok, b_tok, t0, t1;
  logic                 do_fl, do_fr, do_pair, do_end, b_v, a_v;
  csl_kw_t              kw;

  assign at_end  = end_of_source || (source_byte == 8'h00);
  assign run_inc = (run_r == LEN_MAX) ? run_r : run_r + CSL_LEN_W'(1);
  assign pair_k  = csl_pair_kind(held_r, source_byte);
  assign single_k = csl_single_kind(source_byte);

  // Keyword match on the kept prefix of the word
  always_comb begin
    word_kind = K_IDENT;
    kw = '0;
    for (int k = 0; k < CSL_NUM_KEYWORDS; k++) begin
      kw = csl_keyword(4'(k));
      if (int'(kw.len) <= KEYWORD_CHARS && run_r == CSL_LEN_W'(kw.len) &&
          win_r == kw.text[WIN_W-1:0]) begin
        word_kind = K_KW_FIRST + 6'(k);
      end
    end
  end

  // Token held by the current mode, given out when the token ends
  always_comb begin
    fl_v   = 1'b1;
    fl_tok = '0;
    fl_tok.line = tline_r;
    fl_tok.col  = tcol_r;
    case (mode_r)
      M_WORD:        begin fl_tok.kind = word_kind; fl_tok.len = run_r; end
      M_NUMBER:      begin fl_tok.kind = dot_r ? K_FLOAT : K_INT; fl_tok.len = run_r; end
      M_STRING:      begin fl_tok.kind = K_STRING; fl_tok.len = run_r; end
      M_QUOTE_OPEN:  begin fl_tok.kind = K_CHAR; fl_tok.len = CSL_LEN_W'(1); end
      M_QUOTE_VALUE: begin
        fl_tok.kind = K_CHAR;
        fl_tok.len  = CSL_LEN_W'(1);
        fl_tok.cval = lit_r;
      end
      M_HELD:        begin
        fl_tok.kind = csl_single_kind(held_r);
        fl_tok.len  = CSL_LEN_W'(1);
      end
      default:       fl_v = 1'b0;
    endcase
  end

  // Next state for one byte
  always_comb begin
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    dot_nxt   = dot_r;
    win_nxt   = win_r;
    run_nxt   = run_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    cline_nxt = cline_r;
    ccol_nxt  = ccol_r;
    lit_nxt   = lit_r;
    do_fl     = 1'b0;
    do_fr     = 1'b0;
    do_pair   = 1'b0;
    do_end    = 1'b0;
    b_v       = 1'b0;
    b_tok     = '0;

    if (at_end) begin
      // flush, then End, then back to the reset state
      do_fl     = 1'b1;
      do_end    = 1'b1;
      mode_nxt  = M_IDLE;
      held_nxt  = '0;
      dot_nxt   = 1'b0;
      win_nxt   = '0;
      run_nxt   = '0;
      tline_nxt = POS_ONE;
      tcol_nxt  = POS_ONE;
      cline_nxt = POS_ONE;
      ccol_nxt  = POS_ONE;
      lit_nxt   = '0;
      b_tok.kind = K_END;
      b_tok.line = cline_r;
      b_tok.col  = ccol_r;
    end else begin
      // position tracking
      if (source_byte == CH_NL) begin
        cline_nxt = (cline_r == POS_MAX) ? cline_r : cline_r + POS_ONE;
        ccol_nxt  = POS_ONE;
      end else if (ccol_r != POS_MAX) begin
        ccol_nxt = ccol_r + POS_ONE;
      end

      case (mode_r)
        M_WORD: begin
          if (csl_is_letter(source_byte) || csl_is_digit(source_byte)) begin
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
              if (run_r == CSL_LEN_W'(i)) win_nxt[8*i +: 8] = source_byte;
            end
            run_nxt = run_inc;
          end else begin
            do_fl = 1'b1;
            do_fr = 1'b1;
          end
        end
        M_NUMBER: begin
          if (csl_is_digit(source_byte) || (!dot_r && source_byte == CH_DOT)) begin
            if (source_byte == CH_DOT) dot_nxt = 1'b1;
            run_nxt = run_inc;
          end else begin
            do_fl = 1'b1;
            do_fr = 1'b1;
          end
        end
        M_STRING: begin
          if (source_byte == CH_DQUOTE) begin
            do_fl    = 1'b1;
            mode_nxt = M_IDLE;
          end else begin
            run_nxt = run_inc;
          end
        end
        M_QUOTE_OPEN: begin
          lit_nxt  = source_byte;
          mode_nxt = M_QUOTE_VALUE;
        end
        M_QUOTE_VALUE: begin
          do_fl    = 1'b1;
          mode_nxt = M_IDLE;
          if (source_byte != CH_SQUOTE) do_fr = 1'b1;
        end
        M_HELD: begin
          if (held_r == CH_SLASH && source_byte == CH_SLASH) begin
            mode_nxt = M_LINE_REM;
          end else if (held_r == CH_SLASH && source_byte == CH_STAR) begin
            mode_nxt = M_BLOCK_REM;
          end else if (pair_k != 6'd0) begin
            do_pair    = 1'b1;
            mode_nxt   = M_IDLE;
            b_tok.kind = pair_k;
            b_tok.line = tline_r;
            b_tok.col  = tcol_r;
            b_tok.len  = CSL_LEN_W'(2);
          end else begin
            do_fl = 1'b1;
            do_fr = 1'b1;
          end
        end
        M_LINE_REM: begin
          if (source_byte == CH_NL) mode_nxt = M_IDLE;
        end
        M_BLOCK_REM: begin
          if (source_byte == CH_STAR) mode_nxt = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          if (source_byte == CH_SLASH) mode_nxt = M_IDLE;
          else if (source_byte != CH_STAR) mode_nxt = M_BLOCK_REM;
        end
        M_ERROR: begin
          mode_nxt = M_ERROR;
        end
        default: begin
          do_fr = 1'b1;
        end
      endcase

      // byte scanned afresh as the start of a new token
      if (do_fr) begin
        mode_nxt = M_IDLE;
        if (!csl_is_space(source_byte)) begin
          tline_nxt = cline_r;
          tcol_nxt  = ccol_r;
          if (csl_is_letter(source_byte)) begin
            mode_nxt = M_WORD;
            run_nxt  = CSL_LEN_W'(1);
            win_nxt  = WIN_W'(source_byte);
          end else if (csl_is_digit(source_byte)) begin
            mode_nxt = M_NUMBER;
            run_nxt  = CSL_LEN_W'(1);
            dot_nxt  = 1'b0;
          end else if (source_byte == CH_DQUOTE) begin
            mode_nxt = M_STRING;
            run_nxt  = '0;
          end else if (source_byte == CH_SQUOTE) begin
            mode_nxt = M_QUOTE_OPEN;
            lit_nxt  = '0;
          end else if (csl_may_pair(source_byte)) begin
            mode_nxt = M_HELD;
            held_nxt = source_byte;
          end else begin
            b_v        = 1'b1;
            b_tok.line = cline_r;
            b_tok.col  = ccol_r;
            b_tok.len  = CSL_LEN_W'(1);
            if (single_k != 6'd0) begin
              b_tok.kind = single_k;
            end else begin
              b_tok.kind = K_ERROR;
              mode_nxt   = M_ERROR;
            end
          end
        end
      end
    end

    if (do_pair || do_end) b_v = 1'b1;
  end

  // Order the tokens: the flushed one always comes first
  assign a_v = do_fl && fl_v;

  always_comb begin
    t0 = a_v ? fl_tok : b_tok;
    t1 = b_tok;
    t0.last = !(a_v && b_v);
    t1.last = 1'b1;
  end

  assign push.p0 = step && (a_v || b_v);
  assign push.p1 = step && a_v && b_v;
  assign tok0    = t0;
  assign tok1    = t1;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      held_r  <= '0;
      dot_r   <= 1'b0;
      win_r   <= '0;
      run_r   <= '0;
      tline_r <= POS_ONE;
      tcol_r  <= POS_ONE;
      cline_r <= POS_ONE;
      ccol_r  <= POS_ONE;
      lit_r   <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      held_r  <= held_nxt;
      dot_r   <= dot_nxt;
      win_r   <= win_nxt;
      run_r   <= run_nxt;
      tline_r <= tline_nxt;
      tcol_r  <= tcol_nxt;
      cline_r <= cline_nxt;
      ccol_r  <= ccol_nxt;
      lit_r   <= lit_nxt;
    end
  end

endmodule

// ===== hdl/csl_tokq.sv =====
module csl_tokq #(
  parameter int  POSITION_BITS = csl_pkg::CSL_POSITION_BITS,
  localparam int TOK_W         = 2*POSITION_BITS + 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csl_pkg::csl_push_t push,
  input  logic [TOK_W-1:0]   tok0,
  input  logic [TOK_W-1:0]   tok1,
  output logic               room,
  csl_out_if.source          out_chan
);
  import csl_pkg::*;

  localparam int P     = POSITION_BITS;
  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [5:0]           kind;
    logic [P-1:0]         line;
    logic [P-1:0]         col;
    logic [CSL_LEN_W-1:0] len;
    logic [7:0]           cval;
    logic                 last;
  } tok_t;

  tok_t             q_r [DEPTH];
  tok_t             head;
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  // Up to two writes, one read per cycle
  assign pop  = out_chan.valid && out_chan.ready;
  assign room = cnt_r <= CNT_W'(DEPTH - 2);

  always_comb begin
    wr_nxt  = wr_r + PTR_W'(push.p0) + PTR_W'(push.p1);
    rd_nxt  = rd_r + PTR_W'(pop);
    cnt_nxt = cnt_r + CNT_W'(push.p0) + CNT_W'(push.p1) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.p0) q_r[wr_r] <= tok_t'(tok0);
    if (push.p1) q_r[wr_r + PTR_W'(1)] <= tok_t'(tok1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Head of the queue drives the result channel
  assign head                  = q_r[rd_r];
  assign out_chan.valid        = cnt_r != '0;
  assign out_chan.token_kind   = head.kind;
  assign out_chan.start_line   = head.line;
  assign out_chan.start_column = head.col;
  assign out_chan.token_length = head.len;
  assign out_chan.char_value   = head.cval;
  assign out_chan.last_of_run  = head.last;

endmodule
